// ===== rtl/core/lmc_pkg.sv =====
// Shared types, constants and elaboration-time math for the log mel cepstrum unit.
// Used by lmc_ctrl, lmc_datapath and log_mel_cepstrum_unit; depends on nothing.
package lmc_pkg;

   localparam int IDX_W   = 6;   // band and coefficient counters, up to 64
   localparam int ROM_AW  = 12;  // weight ROM address, up to 64 x 64 entries
   localparam int LOG_W   = 22;  // signed Q5.16 log
   localparam int W_W     = 16;  // signed Q1.15 DCT weight
   localparam int LIFT_W  = 24;  // signed Q7.16 lifter
   localparam int FRAC_W  = 24;  // log2 fraction bits
   localparam int NORM_STEPS = 5;

   localparam logic [63:0] PI_Q30  = 64'd3373259426;
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NORM,
      ST_SQR,
      ST_LNMUL,
      ST_STORE,
      ST_DCT,
      ST_DRAIN
   } lmc_state_type;

   typedef struct packed {
      logic              load;
      logic              norm;
      logic [2:0]        norm_step;
      logic              sqr;
      logic              sqr_first;
      logic [4:0]        frac_bit;
      logic              ln_mul;
      logic              store;
      logic [IDX_W-1:0]  store_addr;
      logic              mac;
      logic              mac_first;
      logic              mac_last;
      logic [IDX_W-1:0]  band;
      logic [IDX_W-1:0]  coeff;
      logic [ROM_AW-1:0] rom_addr;
   } lmc_cmd_type;

   typedef struct packed {
      logic frame_done;
   } lmc_status_type;

   // Integer square root, bit-pair method.
   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bits;
      v    = v_in;
      res  = 64'd0;
      bits = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (bits > v) bits = bits >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (bits != 64'd0) begin
            if (v >= res + bits) begin
               v   = v - (res + bits);
               res = (res >> 1) + bits;
            end else begin
               res = res >> 1;
            end
            bits = bits >> 2;
         end
      end
      return res;
   endfunction

   // Taylor series of sin(x) to x^15, x in Q30 within [0, pi/2], truncating terms.
   function automatic logic [63:0] sin_series(input logic [63:0] x);
      logic [63:0] term;
      logic [63:0] sum;
      term = x;
      sum  = x;
      for (int j = 1; j <= 7; j++) begin
         term = (((term * x) >> 30) * x) >> 30;
         unique case (j)
            1:       term = term / 6;
            2:       term = term / 20;
            3:       term = term / 42;
            4:       term = term / 72;
            5:       term = term / 110;
            6:       term = term / 156;
            default: term = term / 210;
         endcase
         if ((j % 2) == 1) sum = sum - term;
         else              sum = sum + term;
      end
      return sum;
   endfunction

endpackage

// ===== rtl/core/lmc_ctrl.sv =====
// Sequencer for the log mel cepstrum unit: log steps per band, MAC sweep per frame.
// Depends on lmc_pkg.
module lmc_ctrl #(
   parameter int BINS = 23,
   parameter int FEAT = 13
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output lmc_pkg::lmc_cmd_type   cmd,
   input  lmc_pkg::lmc_status_type status
);
   import lmc_pkg::*;

   lmc_state_type state_ff, state_in;
   logic [4:0]        step_ff, step_in;
   logic [IDX_W-1:0]  band_ff, band_in;
   logic [IDX_W-1:0]  n_ff, n_in;
   logic [IDX_W-1:0]  k_ff, k_in;
   logic [ROM_AW-1:0] rom_ff, rom_in;

   logic step_end_norm, step_end_sqr, band_last, n_last, k_last;

   assign step_end_norm = (step_ff == 5'(NORM_STEPS - 1));
   assign step_end_sqr  = (step_ff == 5'(FRAC_W - 1));
   assign band_last     = (band_ff == IDX_W'(BINS - 1));
   assign n_last        = (n_ff == IDX_W'(BINS - 1));
   assign k_last        = (k_ff == IDX_W'(FEAT - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (start) state_in = ST_NORM;
         ST_NORM:  if (step_end_norm) state_in = ST_SQR;
         ST_SQR:   if (step_end_sqr) state_in = ST_LNMUL;
         ST_LNMUL: state_in = ST_STORE;
         ST_STORE: state_in = band_last ? ST_DCT : ST_IDLE;
         ST_DCT:   if (n_last && k_last) state_in = ST_DRAIN;
         ST_DRAIN: if (status.frame_done) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // counters
   always_comb begin
      step_in = step_ff;
      band_in = band_ff;
      n_in    = n_ff;
      k_in    = k_ff;
      rom_in  = rom_ff;
      unique case (state_ff)
         ST_IDLE:  step_in = 5'd0;
         ST_NORM:  step_in = step_end_norm ? 5'd0 : step_ff + 5'd1;
         ST_SQR:   step_in = step_ff + 5'd1;
         ST_STORE: begin
            if (band_last) begin
               band_in = '0;
               n_in    = '0;
               k_in    = '0;
               rom_in  = '0;
            end else begin
               band_in = band_ff + IDX_W'(1);
            end
         end
         ST_DCT: begin
            rom_in = rom_ff + ROM_AW'(1);
            if (n_last) begin
               n_in = '0;
               k_in = k_ff + IDX_W'(1);
            end else begin
               n_in = n_ff + IDX_W'(1);
            end
         end
         default: ;
      endcase
   end

   // outputs
   always_comb begin
      cmd            = '0;
      busy           = (state_ff != ST_IDLE);
      cmd.norm_step  = step_ff[2:0];
      cmd.frac_bit   = 5'(FRAC_W - 1) - step_ff;
      cmd.store_addr = band_ff;
      cmd.band       = n_ff;
      cmd.coeff      = k_ff;
      cmd.rom_addr   = rom_ff;
      unique case (state_ff)
         ST_IDLE:  cmd.load = start;
         ST_NORM:  cmd.norm = 1'b1;
         ST_SQR: begin
            cmd.sqr       = 1'b1;
            cmd.sqr_first = (step_ff == 5'd0);
         end
         ST_LNMUL: cmd.ln_mul = 1'b1;
         ST_STORE: cmd.store = 1'b1;
         ST_DCT: begin
            cmd.mac       = 1'b1;
            cmd.mac_first = (n_ff == '0);
            cmd.mac_last  = n_last;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         band_ff  <= '0;
         n_ff     <= '0;
         k_ff     <= '0;
         rom_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         band_ff  <= band_in;
         n_ff     <= n_in;
         k_ff     <= k_in;
         rom_ff   <= rom_in;
      end
   end

endmodule

// ===== rtl/core/lmc_datapath.sv =====
// Datapath: iterative natural log, log store, weight ROMs, MAC and lifter pipeline.
// Depends on lmc_pkg; driven by lmc_ctrl commands.
module lmc_datapath #(
   parameter int BINS     = 23,
   parameter int FEAT     = 13,
   parameter int LIFTER_Q = 22
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lmc_pkg::lmc_cmd_type    cmd,
   input  logic [31:0]             mel_energy,
   output lmc_pkg::lmc_status_type status,
   output logic                    rsp_strobe,
   output logic [3:0]              rsp_coeff_index,
   output logic signed [31:0]      rsp_cepstral_value,
   output logic                    rsp_frame_last
);
   import lmc_pkg::*;

   localparam int AW       = $clog2(BINS);
   localparam int KW       = (FEAT > 1) ? $clog2(FEAT) : 1;
   localparam int RAW      = (FEAT * BINS > 1) ? $clog2(FEAT * BINS) : 1;
   localparam int DCT_DEN  = 2 * BINS;
   localparam int DCT_PER  = 4 * BINS;
   localparam int LIFT_DEN = LIFTER_Q;
   localparam int LIFT_PER = 2 * LIFTER_Q;
   localparam logic [63:0] NORM0 = isqrt64((64'd1 << 60) / BINS);
   localparam logic [63:0] NORMK = isqrt64((64'd1 << 61) / BINS);

   typedef logic [FEAT*BINS-1:0][W_W-1:0] dct_rom_type;
   typedef logic [FEAT-1:0][LIFT_W-1:0]   lift_rom_type;

   function automatic logic signed [63:0] dct_sin(input logic [63:0] num);
      logic [63:0] a;
      logic [63:0] x;
      logic        neg;
      a   = num % 64'(DCT_PER);
      neg = 1'b0;
      if (a >= 64'(DCT_DEN)) begin
         a   = a - 64'(DCT_DEN);
         neg = 1'b1;
      end
      if (2 * a > 64'(DCT_DEN)) a = 64'(DCT_DEN) - a;
      x = (PI_Q30 * a + 64'(DCT_DEN / 2)) / DCT_DEN;
      x = sin_series(x);
      return neg ? -$signed(x) : $signed(x);
   endfunction

   function automatic logic signed [63:0] lift_sin(input logic [63:0] num);
      logic [63:0] a;
      logic [63:0] x;
      logic        neg;
      a   = num % 64'(LIFT_PER);
      neg = 1'b0;
      if (a >= 64'(LIFT_DEN)) begin
         a   = a - 64'(LIFT_DEN);
         neg = 1'b1;
      end
      if (2 * a > 64'(LIFT_DEN)) a = 64'(LIFT_DEN) - a;
      x = (PI_Q30 * a + 64'(LIFT_DEN / 2)) / LIFT_DEN;
      x = sin_series(x);
      return neg ? -$signed(x) : $signed(x);
   endfunction

   function automatic dct_rom_type build_dct();
      dct_rom_type      rom;
      logic signed [63:0] c;
      logic [63:0]      cm;
      logic [63:0]      r;
      logic [63:0]      norm;
      rom = '0;
      for (int k = 0; k < FEAT; k++) begin
         norm = (k == 0) ? NORM0 : NORMK;
         for (int n = 0; n < BINS; n++) begin
            c  = dct_sin(64'((2 * n + 1) * k + BINS));
            cm = (c < 0) ? 64'(-c) : 64'(c);
            r  = (cm * norm + (64'd1 << 44)) >> 45;
            if (c >= 0) rom[k*BINS+n] = (r > 64'd32767) ? 16'sd32767 : W_W'(r);
            else        rom[k*BINS+n] = (r > 64'd32768) ? 16'h8000 : W_W'(-r);
         end
      end
      return rom;
   endfunction

   function automatic lift_rom_type build_lift();
      lift_rom_type       rom;
      logic signed [63:0] s;
      logic [63:0]        sm;
      logic [63:0]        h;
      rom = '0;
      for (int k = 0; k < FEAT; k++) begin
         s  = lift_sin(64'(k));
         sm = (s < 0) ? 64'(-s) : 64'(s);
         h  = (sm * 64'(LIFTER_Q) + (64'd1 << 14)) >> 15;
         rom[k] = (s < 0) ? LIFT_W'(64'd65536 - h) : LIFT_W'(64'd65536 + h);
      end
      return rom;
   endfunction

   localparam dct_rom_type  DCT_ROM  = build_dct();
   localparam lift_rom_type LIFT_ROM = build_lift();

   // ---------------- log unit ----------------
   logic [31:0]        norm_ff, norm_in;
   logic [4:0]         p_ff, p_in;
   logic [30:0]        m_ff;
   logic [FRAC_W-1:0]  frac_ff;
   logic [60:0]        ln_prod_ff;
   logic               ln_neg_ff;

   logic [30:0]        sq_src;
   logic [61:0]        sq;
   logic [31:0]        sq_t;
   logic [4:0]         p_m16;
   logic signed [28:0] l_val;
   logic [28:0]        l_mag;
   logic [61:0]        ln_sum;
   logic [20:0]        ln_r;
   logic signed [LOG_W-1:0] ln_val;

   always_comb begin
      norm_in = norm_ff;
      p_in    = p_ff;
      unique case (cmd.norm_step)
         3'd0: if (norm_ff[31:16] == '0) begin
            norm_in = norm_ff << 16;
            p_in    = p_ff - 5'd16;
         end
         3'd1: if (norm_ff[31:24] == '0) begin
            norm_in = norm_ff << 8;
            p_in    = p_ff - 5'd8;
         end
         3'd2: if (norm_ff[31:28] == '0) begin
            norm_in = norm_ff << 4;
            p_in    = p_ff - 5'd4;
         end
         3'd3: if (norm_ff[31:30] == '0) begin
            norm_in = norm_ff << 2;
            p_in    = p_ff - 5'd2;
         end
         default: if (!norm_ff[31]) begin
            norm_in = norm_ff << 1;
            p_in    = p_ff - 5'd1;
         end
      endcase
   end

   assign sq_src = cmd.sqr_first ? norm_ff[31:1] : m_ff;
   assign sq     = sq_src * sq_src;
   assign sq_t   = sq[61:30];
   assign p_m16  = p_ff - 5'd16;
   assign l_val  = $signed({p_m16, frac_ff});
   assign l_mag  = l_val[28] ? 29'(-l_val) : 29'(l_val);
   assign ln_sum = {1'b0, ln_prod_ff} + (62'd1 << 39);
   assign ln_r   = ln_sum[60:40];
   assign ln_val = ln_neg_ff ? -$signed({1'b0, ln_r}) : $signed({1'b0, ln_r});

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         norm_ff <= (mel_energy == '0) ? 32'd1 : mel_energy;
         p_ff    <= 5'd31;
         frac_ff <= '0;
      end else if (cmd.norm) begin
         norm_ff <= norm_in;
         p_ff    <= p_in;
      end
      if (cmd.sqr) begin
         if (sq_t[31]) begin
            m_ff <= sq_t[31:1];
            frac_ff[cmd.frac_bit] <= 1'b1;
         end else begin
            m_ff <= sq_t[30:0];
         end
      end
      if (cmd.ln_mul) begin
         ln_prod_ff <= 61'(l_mag * LN2_Q32);
         ln_neg_ff  <= l_val[28];
      end
   end

   // ---------------- log store ----------------
   logic signed [LOG_W-1:0] log_mem [BINS];

   always_ff @(posedge clock) begin
      if (cmd.store) log_mem[cmd.store_addr[AW-1:0]] <= ln_val;
   end

   // ---------------- MAC and lifter pipeline ----------------
   logic signed [LOG_W-1:0]  log_q_ff;
   logic signed [W_W-1:0]    w_q_ff;
   logic signed [37:0]       prod_ff;
   logic signed [43:0]       acc_ff;
   logic signed [29:0]       c_ff;
   logic signed [LIFT_W-1:0] lift_ff;
   logic signed [53:0]       lp_ff;
   logic                     v1_ff, first1_ff, last1_ff;
   logic                     v2_ff, first2_ff, last2_ff;
   logic                     fin3_ff, fin4_ff, fin5_ff;
   logic [IDX_W-1:0]         k1_ff, k2_ff, k3_ff, k4_ff, k5_ff, k6_ff;
   logic                     strobe_ff;
   logic signed [31:0]       value_ff;

   logic [43:0]        acc_mag;
   logic [44:0]        acc_sum;
   logic signed [29:0] c_val;
   logic [53:0]        lp_mag;
   logic [54:0]        lp_sum;
   logic [38:0]        lp_r;
   logic signed [31:0] sat_val;

   assign acc_mag = acc_ff[43] ? 44'(-acc_ff) : 44'(acc_ff);
   assign acc_sum = {1'b0, acc_mag} + 45'd16384;
   assign c_val   = acc_ff[43] ? -$signed({1'b0, acc_sum[43:15]})
                               :  $signed({1'b0, acc_sum[43:15]});
   assign lp_mag  = lp_ff[53] ? 54'(-lp_ff) : 54'(lp_ff);
   assign lp_sum  = {1'b0, lp_mag} + 55'd32768;
   assign lp_r    = lp_sum[54:16];

   always_comb begin
      if (lp_ff[53]) begin
         if (lp_r > 39'd2147483648) sat_val = 32'sh8000_0000;
         else                       sat_val = 32'(-$signed({1'b0, lp_r}));
      end else begin
         if (lp_r > 39'd2147483647) sat_val = 32'sh7FFF_FFFF;
         else                       sat_val = 32'(lp_r);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mac) begin
         log_q_ff <= log_mem[cmd.band[AW-1:0]];
         w_q_ff   <= $signed(DCT_ROM[cmd.rom_addr[RAW-1:0]]);
      end
      k1_ff     <= cmd.coeff;
      first1_ff <= cmd.mac_first;
      last1_ff  <= cmd.mac_last;
      prod_ff   <= log_q_ff * w_q_ff;
      k2_ff     <= k1_ff;
      first2_ff <= first1_ff;
      last2_ff  <= last1_ff;
      if (v2_ff) acc_ff <= first2_ff ? 44'(prod_ff) : acc_ff + 44'(prod_ff);
      k3_ff <= k2_ff;
      if (fin3_ff) begin
         c_ff    <= c_val;
         lift_ff <= $signed(LIFT_ROM[k3_ff[KW-1:0]]);
      end
      k4_ff <= k3_ff;
      if (fin4_ff) lp_ff <= c_ff * lift_ff;
      k5_ff <= k4_ff;
      if (fin5_ff) begin
         value_ff <= sat_val;
         k6_ff    <= k5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         fin3_ff   <= 1'b0;
         fin4_ff   <= 1'b0;
         fin5_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         v1_ff     <= cmd.mac;
         v2_ff     <= v1_ff;
         fin3_ff   <= v2_ff & last2_ff;
         fin4_ff   <= fin3_ff;
         fin5_ff   <= fin4_ff;
         strobe_ff <= fin5_ff;
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_coeff_index    = k6_ff[3:0];
   assign rsp_cepstral_value = value_ff;
   assign rsp_frame_last     = (k6_ff == IDX_W'(FEAT - 1));
   assign status.frame_done  = strobe_ff & rsp_frame_last;

endmodule

// ===== rtl/core/log_mel_cepstrum_unit.sv =====
// Top level of the log mel cepstrum unit: controller plus datapath.
// Depends on lmc_pkg, lmc_ctrl and lmc_datapath.
//
// Feed one mel band energy (unsigned Q16.16, ascending band order) per transfer:
// raise start with req_mel_energy while busy is low. A band is done before the
// next transfer can be taken: capture, normalization of the energy, one squaring
// per fraction bit through the single log multiplier, an ln2 multiply and a
// store into the log RAM. The band that completes a frame then starts a sweep
// through the single MAC, one RAM read and one weight ROM read per cycle,
// followed by the round, lifter and saturation pipeline. Each of the FEAT results
// shows on the rsp_ ports for exactly one cycle with rsp_strobe high; there is no
// back pressure, so capture them when they appear. busy stays high until the last
// coefficient of a frame (rsp_frame_last) has been shown.
module log_mel_cepstrum_unit #(
   parameter int BINS     = 23,
   parameter int FEAT     = 13,
   parameter int LIFTER_Q = 22
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [31:0]        req_mel_energy,
   output logic               rsp_strobe,
   output logic [3:0]         rsp_coeff_index,
   output logic signed [31:0] rsp_cepstral_value,
   output logic               rsp_frame_last
);
   import lmc_pkg::*;

   lmc_cmd_type    cmd;
   lmc_status_type status;

   // sequence the log steps and the coefficient sweep
   lmc_ctrl #(
      .BINS (BINS),
      .FEAT (FEAT)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   // hold the logs, run the MAC and drive the result transfer
   lmc_datapath #(
      .BINS     (BINS),
      .FEAT     (FEAT),
      .LIFTER_Q (LIFTER_Q)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .mel_energy         (req_mel_energy),
      .status             (status),
      .rsp_strobe         (rsp_strobe),
      .rsp_coeff_index    (rsp_coeff_index),
      .rsp_cepstral_value (rsp_cepstral_value),
      .rsp_frame_last     (rsp_frame_last)
   );

   // results only appear while a frame is in flight
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result shown while idle");

   // the last coefficient of a frame releases the block
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_frame_last |=> !busy && !rsp_strobe)
      else $error("block still busy after the frame's last coefficient");

   // a transfer always starts work
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("transfer taken without going busy");

endmodule

// ===== test/lmc_checker.sv =====
// Scoreboard for the log mel cepstrum unit: watches the request and response
// channels, predicts each coefficient and compares. Depends on nothing but its ports.
`timescale 1ns / 100ps

module lmc_checker #(
   parameter int BINS     = 23,
   parameter int FEAT     = 13,
   parameter int LIFTER_Q = 22
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [31:0]        req_mel_energy,
   input  logic               rsp_strobe,
   input  logic [3:0]         rsp_coeff_index,
   input  logic signed [31:0] rsp_cepstral_value,
   input  logic               rsp_frame_last,
   output int                 fail_count,
   output int                 coeffs_pending
);

   localparam logic [63:0] PI_Q30 = 64'd3373259426;
   localparam logic [63:0] LN2_Q32 = 64'd2977044472;

   typedef struct {
      logic [3:0]         index;
      logic signed [31:0] value;
      logic               last;
   } coeff_type;

   coeff_type coeff_queue[$];
   longint    dct_weight[FEAT][BINS];
   longint    lifter_gain[FEAT];
   longint    log_band[BINS];
   int        bands_seen;

   function automatic logic [63:0] root64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] b;
      v   = v_in;
      res = 0;
      b   = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v   = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // sin(pi*num/den) in Q30
   function automatic longint sine_q30(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] a;
      logic [63:0] x;
      logic [63:0] term;
      logic [63:0] sum;
      bit          neg;
      a   = num % (2 * den);
      neg = 0;
      if (a >= den) begin
         a   = a - den;
         neg = 1;
      end
      if (2 * a > den) a = den - a;
      x    = (PI_Q30 * a + den / 2) / den;
      term = x;
      sum  = x;
      for (int j = 1; j <= 7; j++) begin
         term = (((term * x) >> 30) * x) >> 30;
         term = term / ((2 * j) * (2 * j + 1));
         if (j % 2) sum = sum - term;
         else       sum = sum + term;
      end
      return neg ? -longint'(sum) : longint'(sum);
   endfunction

   function automatic longint round_q(input longint v, input int s);
      logic [63:0] half;
      half = 64'd1 << (s - 1);
      if (v < 0) return -longint'((64'(-v) + half) >> s);
      return longint'((64'(v) + half) >> s);
   endfunction

   // Natural log of a Q16.16 energy, floored at one LSB, in Q5.16
   function automatic longint ln_energy(input logic [31:0] x_in);
      logic [31:0] x;
      logic [63:0] m;
      logic [63:0] frac;
      logic [63:0] mag;
      longint      l;
      longint      r;
      int          p;
      x = (x_in == 0) ? 32'd1 : x_in;
      p = 31;
      while (!x[p]) p--;
      m    = (p <= 30) ? (64'(x) << (30 - p)) : (64'(x) >> 1);
      frac = 0;
      for (int i = 23; i >= 0; i--) begin
         m = (m * m) >> 30;
         if (m >= (64'd1 << 31)) begin
            m    = m >> 1;
            frac = frac | (64'd1 << i);
         end
      end
      l   = (longint'(p) - 16) * (longint'(1) << 24) + longint'(frac);
      mag = (l < 0) ? -l : l;
      r   = longint'((mag * LN2_Q32 + (64'd1 << 39)) >> 40);
      return (l < 0) ? -r : r;
   endfunction

   initial begin
      logic [63:0] norm_dc;
      logic [63:0] norm_ac;
      logic [63:0] norm;
      logic [63:0] h;
      logic [63:0] r;
      longint      s;
      longint      c;
      norm_dc = root64((64'd1 << 60) / BINS);
      norm_ac = root64((64'd1 << 61) / BINS);
      for (int k = 0; k < FEAT; k++) begin
         norm = (k == 0) ? norm_dc : norm_ac;
         s    = sine_q30(k, LIFTER_Q);
         h    = (64'((s < 0) ? -s : s) * LIFTER_Q + (64'd1 << 14)) >> 15;
         lifter_gain[k] = (s < 0) ? 65536 - longint'(h) : 65536 + longint'(h);
         for (int n = 0; n < BINS; n++) begin
            c = sine_q30((2 * n + 1) * k + BINS, 2 * BINS);
            r = (64'((c < 0) ? -c : c) * norm + (64'd1 << 44)) >> 45;
            if (c >= 0) dct_weight[k][n] = (r > 32767) ? 32767 : longint'(r);
            else        dct_weight[k][n] = (r > 32768) ? -32768 : -longint'(r);
         end
      end
   end

   // Store one band; on the last band of a frame, queue all coefficients.
   task automatic predict_band(input logic [31:0] energy);
      longint    acc;
      longint    c;
      longint    r;
      coeff_type e;
      log_band[bands_seen] = ln_energy(energy);
      bands_seen++;
      if (bands_seen == BINS) begin
         bands_seen = 0;
         for (int k = 0; k < FEAT; k++) begin
            acc = 0;
            for (int n = 0; n < BINS; n++) acc += log_band[n] * dct_weight[k][n];
            c = round_q(acc, 15);
            r = round_q(c * lifter_gain[k], 16);
            if (r > 64'sd2147483647) r = 64'sd2147483647;
            if (r < -64'sd2147483648) r = -64'sd2147483648;
            e.index = k[3:0];
            e.value = r[31:0];
            e.last  = (k == FEAT - 1);
            coeff_queue.push_back(e);
         end
      end
   endtask

   always @(posedge clock) begin
      coeff_type e;
      if (reset) begin
         bands_seen = 0;
         fail_count = 0;
         coeff_queue.delete();
      end else begin
         if (rsp_strobe) begin
            if (coeff_queue.size() == 0) begin
               $error("unexpected coefficient: index %0d value %0d",
                      rsp_coeff_index, rsp_cepstral_value);
               fail_count++;
            end else begin
               e = coeff_queue.pop_front();
               if (rsp_coeff_index !== e.index) begin
                  $error("coeff_index: expected %0d, got %0d", e.index, rsp_coeff_index);
                  fail_count++;
               end
               if (rsp_cepstral_value !== e.value) begin
                  $error("cepstral_value: expected %0d, got %0d", e.value,
                         rsp_cepstral_value);
                  fail_count++;
               end
               if (rsp_frame_last !== e.last) begin
                  $error("frame_last: expected %0b, got %0b", e.last, rsp_frame_last);
                  fail_count++;
               end
            end
         end
         if (start && !busy) predict_band(req_mel_energy);
      end
      coeffs_pending = coeff_queue.size();
   end

endmodule

// ===== test/log_mel_cepstrum_unit_tb.sv =====
// Testbench top for log_mel_cepstrum_unit: clock, reset, band stimulus and verdict.
// Depends on the unit itself (and through it on lmc_pkg) and on lmc_checker.
`timescale 1ns / 100ps

module log_mel_cepstrum_unit_tb;

   localparam int BINS       = 23;
   localparam int FEAT       = 13;
   localparam int LIFTER_Q   = 22;
   localparam int FRAMES     = 9;        // random frames after the directed ones
   localparam int DRAIN_WAIT = 400;      // one full coefficient sweep plus margin
   localparam int CYCLE_CAP  = 300000;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [31:0]        req_mel_energy;
   logic               rsp_strobe;
   logic [3:0]         rsp_coeff_index;
   logic signed [31:0] rsp_cepstral_value;
   logic               rsp_frame_last;
   int                 fail_count;
   int                 coeffs_pending;
   int                 cycle_count;

   log_mel_cepstrum_unit #(
      .BINS(BINS), .FEAT(FEAT), .LIFTER_Q(LIFTER_Q)
   ) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mel_energy(req_mel_energy), .rsp_strobe(rsp_strobe),
      .rsp_coeff_index(rsp_coeff_index), .rsp_cepstral_value(rsp_cepstral_value),
      .rsp_frame_last(rsp_frame_last)
   );

   lmc_checker #(
      .BINS(BINS), .FEAT(FEAT), .LIFTER_Q(LIFTER_Q)
   ) checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mel_energy(req_mel_energy), .rsp_strobe(rsp_strobe),
      .rsp_coeff_index(rsp_coeff_index), .rsp_cepstral_value(rsp_cepstral_value),
      .rsp_frame_last(rsp_frame_last), .fail_count(fail_count),
      .coeffs_pending(coeffs_pending)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // Watchdog: abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("log_mel_cepstrum_unit verification failed");
         $finish;
      end
   end

   // Mostly back-to-back or short gaps, with an occasional long idle stretch.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 0;
      if (roll < 90) return $urandom_range(1, 4);
      return $urandom_range(20, 120);
   endfunction

   // Random band energy: full range, small values near the floor, powers of two,
   // values around unity and just below all ones, so the log covers its whole span.
   function automatic logic [31:0] pick_energy();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 35) return $urandom();
      if (roll < 50) return $urandom_range(0, 3);
      if (roll < 65) return 32'd1 << $urandom_range(0, 31);
      if (roll < 80) return 32'h0001_0000 + $urandom_range(0, 255) - 128;
      if (roll < 90) return 32'hFFFF_FFFF - $urandom_range(0, 15);
      return $urandom() >> $urandom_range(0, 31);
   endfunction

   // Hold start and the energy until the transfer completes; idle gap before it.
   task automatic send_band(input logic [31:0] energy, input int gap);
      bit taken;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start          <= 1'b1;
      req_mel_energy <= energy;
      taken = 0;
      while (!taken) begin
         // busy is settled at the falling edge and holds to the next rising one
         taken = !busy;
         @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (coeffs_pending != 0 || busy) @(negedge clock);
   endtask

   initial begin
      logic [31:0] directed_bands[BINS];
      reset          = 1'b1;
      start          = 1'b0;
      req_mel_energy = 32'd0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // Directed frame: zero floor, one LSB, unity, all ones, alternating bits, walking bits.
      directed_bands[0] = 32'd0;
      directed_bands[1] = 32'd1;
      directed_bands[2] = 32'hFFFF_FFFF;
      directed_bands[3] = 32'h0001_0000;
      directed_bands[4] = 32'h8000_0000;
      directed_bands[5] = 32'h5555_5555;
      directed_bands[6] = 32'hAAAA_AAAA;
      directed_bands[7] = 32'h0000_FFFF;
      directed_bands[8] = 32'h0001_0001;
      for (int n = 9; n < BINS; n++) directed_bands[n] = 32'd1 << (n + 8);
      foreach (directed_bands[n]) send_band(directed_bands[n], 0);
      wait_drained();

      // Saturating extremes: a frame of all ones and one of all floors.
      for (int n = 0; n < BINS; n++) send_band(32'hFFFF_FFFF, 0);
      wait_drained();
      for (int n = 0; n < BINS; n++) send_band(32'd0, n % 2);

      for (int f = 0; f < FRAMES; f++) begin
         for (int n = 0; n < BINS; n++) send_band(pick_energy(), pick_gap());
         // hold off once mid-run until every coefficient is out
         if (f == FRAMES / 2) wait_drained();
      end

      wait_drained();
      repeat (DRAIN_WAIT) @(negedge clock);
      if (fail_count == 0) begin
         $display("log_mel_cepstrum_unit verification clean");
      end else begin
         $display("log_mel_cepstrum_unit verification failed");
      end
      $finish;
   end

endmodule
